@@ rtl/pbw_pkg.sv @@
// Shared types and constants of the periodic box wrap block.
`default_nettype none

package pbw_pkg;

    localparam int unsigned LW       = 31;             // box length / remainder width
    localparam int unsigned CW       = 32;             // coordinate width
    localparam int unsigned SHW      = 18;             // shear fraction width
    localparam int unsigned SF       = 16;             // shear fraction bits
    localparam int unsigned FW       = LW + SF;        // fraction times length
    localparam int unsigned KXW      = SF + 1;         // x image count bits kept
    localparam logic [LW-1:0] LEN_RST = LW'(65536);    // 1.0 in Q15.16
    localparam logic [FW-1:0] HALF   = FW'(1) << (SF - 1);

    typedef enum logic [2:0] {
        REG_LEN_X    = 3'd0,
        REG_LEN_Y    = 3'd1,
        REG_LEN_Z    = 3'd2,
        REG_SHEAR_XY = 3'd3,
        REG_SHEAR_ZX = 3'd4,
        REG_SHEAR_ZY = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic               operation;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } t_pbw_in;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
    } t_pbw_out;

endpackage

`default_nettype wire

@@ rtl/pbw_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with sideband.
`default_nettype none

module pbw_div #(
    parameter int unsigned NW = 32,
    parameter int unsigned SW = 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [NW-1:0]          i_num,
    input  logic [pbw_pkg::LW-1:0] i_den,
    input  logic [SW-1:0]          i_side,
    output logic                   o_valid,
    output logic [NW-1:0]          o_quot,
    output logic [pbw_pkg::LW-1:0] o_rem,
    output logic [SW-1:0]          o_side
);
    import pbw_pkg::*;

    logic [NW-1:0] r_valid;
    logic [NW-1:0] r_num  [NW];
    logic [LW-1:0] r_rem  [NW];
    logic [SW-1:0] r_side [NW];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic          vld_in;
        logic [NW-1:0] num_in;
        logic [LW-1:0] rem_in;
        logic [SW-1:0] side_in;
        logic [LW:0]   trial;
        logic [LW+1:0] diff;
        logic [LW-1:0] n_rem;
        logic [NW-1:0] n_num;

        if (k == 0) begin : g_first
            assign vld_in  = i_valid;
            assign num_in  = i_num;
            assign rem_in  = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign vld_in  = r_valid[k-1];
            assign num_in  = r_num[k-1];
            assign rem_in  = r_rem[k-1];
            assign side_in = r_side[k-1];
        end

        // bring down next dividend bit, quotient bit shifts in at the bottom
        assign trial = {rem_in, num_in[NW-1]};
        assign diff  = {1'b0, trial} - {2'b00, i_den};
        assign n_rem = diff[LW+1] ? trial[LW-1:0] : diff[LW-1:0];
        assign n_num = {num_in[NW-2:0], ~diff[LW+1]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[k]  <= n_num;
                r_rem[k]  <= n_rem;
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid = r_valid[NW-1];
    assign o_quot  = r_num[NW-1];
    assign o_rem   = r_rem[NW-1];
    assign o_side  = r_side[NW-1];

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (i_den != '0) |-> o_rem < i_den)
        else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

@@ rtl/pbw_reduce.sv @@
// Floor fix-up, image bias and round-half-even step of one axis (2 stages).
`default_nettype none

module pbw_reduce #(
    parameter int unsigned QW = 17,
    parameter int unsigned SW = 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic                   i_nearest,
    input  logic                   i_neg,
    input  logic [QW-1:0]          i_qmag,
    input  logic [pbw_pkg::LW-1:0] i_rmag,
    input  logic [QW-1:0]          i_bias,
    input  logic [pbw_pkg::LW-1:0] i_len,
    input  logic [pbw_pkg::CW-1:0] i_alow,
    input  logic [SW-1:0]          i_side,
    output logic                   o_valid,
    output logic [QW-1:0]          o_count,
    output logic [pbw_pkg::CW-1:0] o_coord,
    output logic [SW-1:0]          o_side
);
    import pbw_pkg::*;

    logic          r1_valid;
    logic          r1_near;
    logic [QW-1:0] r1_q;
    logic [LW-1:0] r1_r;
    logic [CW-1:0] r1_alow;
    logic [SW-1:0] r1_side;
    logic [QW-1:0] n1_q;
    logic [LW-1:0] n1_r;

    logic          r2_valid;
    logic [QW-1:0] r2_count;
    logic [CW-1:0] r2_coord;
    logic [SW-1:0] r2_side;
    logic [LW:0]   twice;
    logic [LW:0]   len_ext;
    logic          up;
    logic          zero_len;
    logic [QW-1:0] n2_count;
    logic [CW-1:0] n2_coord;

    // negative dividend: q = -q'-1, r = d-1-r'
    assign n1_q = (i_neg ? ~i_qmag : i_qmag) - i_bias;
    assign n1_r = i_neg ? (i_len - LW'(1) - i_rmag) : i_rmag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_near  <= i_nearest;
            r1_q     <= n1_q;
            r1_r     <= n1_r;
            r1_alow  <= i_alow;
            r1_side  <= i_side;
            r2_count <= n2_count;
            r2_coord <= n2_coord;
            r2_side  <= r1_side;
        end
    end

    assign twice    = {r1_r, 1'b0};
    assign len_ext  = {1'b0, i_len};
    assign up       = r1_near && ((twice > len_ext) || ((twice == len_ext) && r1_q[0]));
    assign zero_len = (i_len == '0);

    always_comb begin
        if (zero_len) begin
            n2_count = '0;
            n2_coord = r1_alow;
        end else if (up) begin
            n2_count = r1_q + QW'(1);
            n2_coord = {1'b0, r1_r} - {1'b0, i_len};
        end else begin
            n2_count = r1_q;
            n2_coord = {1'b0, r1_r};
        end
    end

    assign o_valid = r2_valid;
    assign o_count = r2_count;
    assign o_coord = r2_coord;
    assign o_side  = r2_side;

    a_coord_in_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (i_len != '0) |->
            ($signed(o_coord) < $signed({1'b0, i_len})) &&
            ($signed(o_coord) > -$signed({1'b0, i_len})))
        else $error("reduced coordinate outside one box length");

    a_zero_len_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (i_len == '0) |-> o_count == '0)
        else $error("image count nonzero for zero length");

endmodule

`default_nettype wire

@@ rtl/pbw_offset.sv @@
// Shear offset split: shear*count into whole lengths and a rounded remainder (3 stages).
`default_nettype none

module pbw_offset #(
    parameter int unsigned QW = 17,
    parameter int unsigned KW = 1,
    parameter int unsigned SW = 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic signed [pbw_pkg::SHW-1:0] i_shear,
    input  logic [QW-1:0]                  i_count,
    input  logic [pbw_pkg::LW-1:0]         i_len,
    input  logic [SW-1:0]                  i_side,
    output logic                           o_valid,
    output logic [KW-1:0]                  o_k,
    output logic [pbw_pkg::LW-1:0]         o_rem,
    output logic [SW-1:0]                  o_side
);
    import pbw_pkg::*;

    localparam int unsigned PW = SF + KW;

    logic signed [SHW+QW-1:0] prod;
    logic [FW-1:0]            rsum;

    logic [2:0]    r_valid;
    logic [PW-1:0] r1_p;
    logic [SW-1:0] r1_side;
    logic [FW-1:0] r2_f;
    logic [KW-1:0] r2_k;
    logic [SW-1:0] r2_side;
    logic [KW-1:0] r3_k;
    logic [LW-1:0] r3_rem;
    logic [SW-1:0] r3_side;

    // only the low PW bits of the product matter downstream
    assign prod = i_shear * $signed(i_count);
    assign rsum = r2_f + HALF;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_p    <= prod[PW-1:0];
            r1_side <= i_side;
            r2_f    <= r1_p[SF-1:0] * i_len;
            r2_k    <= r1_p[PW-1:SF];
            r2_side <= r1_side;
            r3_rem  <= rsum[FW-1:SF];
            r3_k    <= r2_k;
            r3_side <= r2_side;
        end
    end

    assign o_valid = r_valid[2];
    assign o_k     = r3_k;
    assign o_rem   = r3_rem;
    assign o_side  = r3_side;

endmodule

`default_nettype wire

@@ rtl/pbw_skid.sv @@
// Output register with one skid entry.
`default_nettype none

module pbw_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  pbw_pkg::t_pbw_out i_data,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_ready,
    output pbw_pkg::t_pbw_out o_data
);
    import pbw_pkg::*;

    logic     r_full;
    logic     r_out_valid;
    t_pbw_out r_skid;
    t_pbw_out r_out;
    logic     in_fire;

    assign in_fire = i_valid && !r_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full      <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            r_out_valid <= r_full || in_fire;
            r_full      <= 1'b0;
        end else if (in_fire) begin
            r_full      <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_ready) begin
            r_out <= r_full ? r_skid : i_data;
        end else if (in_fire) begin
            r_skid <= i_data;
        end
    end

    assign o_ready = !r_full;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |-> r_out_valid)
        else $error("skid entry held while output register empty");

endmodule

`default_nettype wire

@@ rtl/periodic_box_wrap_core.sv @@
// Top level of the sheared periodic box wrap / nearest image pipeline.
//
//  port group      dir  handshake               word
//  i_in_*          in   i_in_valid/o_in_ready   t_pbw_in  (operation, pos_x/y/z)
//  o_out_*         out  o_out_valid/i_out_ready t_pbw_out (out_x/y/z)
//  i_cfg_*         in   i_cfg_we, no wait       index 0..5, 31-bit data
//
//  One word enters per cycle while the output skid entry is free. Each word
//  passes three bit-serial divider pipelines (31, 32 and 33 stages, one quotient
//  bit each), 2 fix-up, 3 shear and 1 subtract stages behind the z and x dividers,
//  2 fix-up stages behind the y divider and the output register.
//  Reset (synchronous, active low) clears all valid bits and sets lengths to 1.0.
//  The whole pipeline advances together; it halts only when the skid entry at
//  the output is occupied, so one more word is taken after the output stalls.
`default_nettype none

module periodic_box_wrap_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  pbw_pkg::t_pbw_in i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output pbw_pkg::t_pbw_out o_out_data,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_idx,
    input  logic [30:0]      i_cfg_data
);
    import pbw_pkg::*;

    // sideband carried alongside each section
    typedef struct packed {
        logic          op;
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic          neg;
        logic [CW-1:0] z;
    } t_zd_side;

    typedef struct packed {
        logic          op;
        logic [CW-1:0] x;
        logic [CW-1:0] y;
    } t_zr_side;

    typedef struct packed {
        logic          op;
        logic [CW-1:0] x;
    } t_zx_side;

    typedef struct packed {
        logic [CW-1:0] y;
        logic [CW-1:0] zf;
    } t_zy_side;

    typedef struct packed {
        logic           op;
        logic           neg;
        logic [CW-1:0]  alow;
        logic [KXW-1:0] kzx;
        logic           kzy;
        logic [CW:0]    ypart;
        logic [CW-1:0]  zf;
    } t_xd_side;

    typedef struct packed {
        logic          op;
        logic          kzy;
        logic [CW:0]   ypart;
        logic [CW-1:0] zf;
    } t_xr_side;

    typedef struct packed {
        logic          op;
        logic          kzy;
        logic [CW:0]   ypart;
        logic [CW-1:0] zf;
        logic [CW-1:0] xf;
    } t_xo_side;

    typedef struct packed {
        logic          op;
        logic          neg;
        logic [CW-1:0] alow;
        logic          bias;
        logic [CW-1:0] xf;
        logic [CW-1:0] zf;
    } t_yd_side;

    typedef struct packed {
        logic [CW-1:0] xf;
        logic [CW-1:0] zf;
    } t_yr_side;

    // configuration registers
    logic [LW-1:0]         r_len_x;
    logic [LW-1:0]         r_len_y;
    logic [LW-1:0]         r_len_z;
    logic signed [SHW-1:0] r_shear_xy;
    logic signed [SHW-1:0] r_shear_zx;
    logic signed [SHW-1:0] r_shear_zy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_x    <= LEN_RST;
            r_len_y    <= LEN_RST;
            r_len_z    <= LEN_RST;
            r_shear_xy <= '0;
            r_shear_zx <= '0;
            r_shear_zy <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_LEN_X:    r_len_x    <= i_cfg_data;
                REG_LEN_Y:    r_len_y    <= i_cfg_data;
                REG_LEN_Z:    r_len_z    <= i_cfg_data;
                REG_SHEAR_XY: r_shear_xy <= i_cfg_data[SHW-1:0];
                REG_SHEAR_ZX: r_shear_zx <= i_cfg_data[SHW-1:0];
                REG_SHEAR_ZY: r_shear_zy <= i_cfg_data[SHW-1:0];
                default: ;
            endcase
        end
    end

    // global advance: everything moves unless the skid entry is taken
    logic en;

    // ---------------- z axis: floor(z / Lz), then nearest fix-up
    logic          z_neg;
    logic [LW-1:0] z_mag;
    t_zd_side      zd_in;
    t_zd_side      zd_out;
    logic          zd_valid;
    logic [LW-1:0] zd_quot;
    logic [LW-1:0] zd_rem;

    assign z_neg = i_in_data.pos_z[CW-1];
    assign z_mag = z_neg ? ~i_in_data.pos_z[LW-1:0] : i_in_data.pos_z[LW-1:0];
    assign zd_in = '{op: i_in_data.operation, x: i_in_data.pos_x, y: i_in_data.pos_y,
                     neg: z_neg, z: i_in_data.pos_z};

    pbw_div #(.NW(LW), .SW($bits(t_zd_side))) u_div_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_num   (z_mag),
        .i_den   (r_len_z),
        .i_side  (zd_in),
        .o_valid (zd_valid),
        .o_quot  (zd_quot),
        .o_rem   (zd_rem),
        .o_side  (zd_out)
    );

    logic          zr_valid;
    logic [CW:0]   nz;
    logic [CW-1:0] zf;
    t_zr_side      zr_out;

    pbw_reduce #(.QW(CW + 1), .SW($bits(t_zr_side))) u_red_z (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (zd_valid),
        .i_nearest (zd_out.op),
        .i_neg     (zd_out.neg),
        .i_qmag    ({2'b00, zd_quot}),
        .i_rmag    (zd_rem),
        .i_bias    ('0),
        .i_len     (r_len_z),
        .i_alow    (zd_out.z),
        .i_side    ({zd_out.op, zd_out.x, zd_out.y}),
        .o_valid   (zr_valid),
        .o_count   (nz),
        .o_coord   (zf),
        .o_side    (zr_out)
    );

    // ---------------- z image shear offsets on x and y
    logic           zx_valid;
    logic [KXW-1:0] kzx;
    logic [LW-1:0]  rzx;
    t_zx_side       zx_out;
    logic           kzy;
    logic [LW-1:0]  rzy;
    t_zy_side       zy_out;

    pbw_offset #(.QW(CW + 1), .KW(KXW), .SW($bits(t_zx_side))) u_off_zx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (zr_valid),
        .i_shear (r_shear_zx),
        .i_count (nz),
        .i_len   (r_len_x),
        .i_side  ({zr_out.op, zr_out.x}),
        .o_valid (zx_valid),
        .o_k     (kzx),
        .o_rem   (rzx),
        .o_side  (zx_out)
    );

    // only the parity of the y bias is needed, so 17 count bits suffice
    pbw_offset #(.QW(KXW), .KW(1), .SW($bits(t_zy_side))) u_off_zy (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (zr_valid),
        .i_shear (r_shear_zy),
        .i_count (nz[KXW-1:0]),
        .i_len   (r_len_y),
        .i_side  ({zr_out.y, zf}),
        .o_valid (),
        .o_k     (kzy),
        .o_rem   (rzy),
        .o_side  (zy_out)
    );

    // ---------------- subtract shear remainders from x and y
    logic           r_xp_valid;
    logic [CW:0]    r_xp_ax;
    logic [CW:0]    r_xp_ypart;
    logic           r_xp_op;
    logic [KXW-1:0] r_xp_kzx;
    logic           r_xp_kzy;
    logic [CW-1:0]  r_xp_zf;
    logic [CW:0]    n_xp_ax;
    logic [CW:0]    n_xp_ypart;

    assign n_xp_ax    = {zx_out.x[CW-1], zx_out.x} - {2'b00, rzx};
    assign n_xp_ypart = {zy_out.y[CW-1], zy_out.y} - {2'b00, rzy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xp_valid <= 1'b0;
        end else if (en) begin
            r_xp_valid <= zx_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_xp_ax    <= n_xp_ax;
            r_xp_ypart <= n_xp_ypart;
            r_xp_op    <= zx_out.op;
            r_xp_kzx   <= kzx;
            r_xp_kzy   <= kzy;
            r_xp_zf    <= zy_out.zf;
        end
    end

    // ---------------- x axis: floor((x - rzx) / Lx) - kzx
    logic          x_neg;
    logic [CW-1:0] x_mag;
    t_xd_side      xd_in;
    t_xd_side      xd_out;
    logic          xd_valid;
    logic [CW-1:0] xd_quot;
    logic [LW-1:0] xd_rem;

    assign x_neg = r_xp_ax[CW];
    assign x_mag = x_neg ? ~r_xp_ax[CW-1:0] : r_xp_ax[CW-1:0];
    assign xd_in = '{op: r_xp_op, neg: x_neg, alow: r_xp_ax[CW-1:0], kzx: r_xp_kzx,
                     kzy: r_xp_kzy, ypart: r_xp_ypart, zf: r_xp_zf};

    pbw_div #(.NW(CW), .SW($bits(t_xd_side))) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_xp_valid),
        .i_num   (x_mag),
        .i_den   (r_len_x),
        .i_side  (xd_in),
        .o_valid (xd_valid),
        .o_quot  (xd_quot),
        .o_rem   (xd_rem),
        .o_side  (xd_out)
    );

    logic           xr_valid;
    logic [KXW-1:0] nx;
    logic [CW-1:0]  xf;
    t_xr_side       xr_out;

    pbw_reduce #(.QW(KXW), .SW($bits(t_xr_side))) u_red_x (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (xd_valid),
        .i_nearest (xd_out.op),
        .i_neg     (xd_out.neg),
        .i_qmag    (xd_quot[KXW-1:0]),
        .i_rmag    (xd_rem),
        .i_bias    (xd_out.kzx),
        .i_len     (r_len_x),
        .i_alow    (xd_out.alow),
        .i_side    ({xd_out.op, xd_out.kzy, xd_out.ypart, xd_out.zf}),
        .o_valid   (xr_valid),
        .o_count   (nx),
        .o_coord   (xf),
        .o_side    (xr_out)
    );

    // ---------------- x image shear offset on y
    logic          xo_valid;
    logic          kxy;
    logic [LW-1:0] rxy;
    t_xo_side      xo_out;

    pbw_offset #(.QW(KXW), .KW(1), .SW($bits(t_xo_side))) u_off_xy (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (xr_valid),
        .i_shear (r_shear_xy),
        .i_count (nx),
        .i_len   (r_len_y),
        .i_side  ({xr_out.op, xr_out.kzy, xr_out.ypart, xr_out.zf, xf}),
        .o_valid (xo_valid),
        .o_k     (kxy),
        .o_rem   (rxy),
        .o_side  (xo_out)
    );

    logic          r_yp_valid;
    logic [CW+1:0] r_yp_ay;
    logic          r_yp_bias;
    logic          r_yp_op;
    logic [CW-1:0] r_yp_xf;
    logic [CW-1:0] r_yp_zf;
    logic [CW+1:0] n_yp_ay;

    assign n_yp_ay = {xo_out.ypart[CW], xo_out.ypart} - {3'b000, rxy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_yp_valid <= 1'b0;
        end else if (en) begin
            r_yp_valid <= xo_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_yp_ay   <= n_yp_ay;
            r_yp_bias <= xo_out.kzy ^ kxy;
            r_yp_op   <= xo_out.op;
            r_yp_xf   <= xo_out.xf;
            r_yp_zf   <= xo_out.zf;
        end
    end

    // ---------------- y axis: only the quotient parity matters
    logic          y_neg;
    logic [CW:0]   y_mag;
    t_yd_side      yd_in;
    t_yd_side      yd_out;
    logic          yd_valid;
    logic [CW:0]   yd_quot;
    logic [LW-1:0] yd_rem;

    assign y_neg = r_yp_ay[CW+1];
    assign y_mag = y_neg ? ~r_yp_ay[CW:0] : r_yp_ay[CW:0];
    assign yd_in = '{op: r_yp_op, neg: y_neg, alow: r_yp_ay[CW-1:0], bias: r_yp_bias,
                     xf: r_yp_xf, zf: r_yp_zf};

    pbw_div #(.NW(CW + 1), .SW($bits(t_yd_side))) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_yp_valid),
        .i_num   (y_mag),
        .i_den   (r_len_y),
        .i_side  (yd_in),
        .o_valid (yd_valid),
        .o_quot  (yd_quot),
        .o_rem   (yd_rem),
        .o_side  (yd_out)
    );

    logic          yr_valid;
    logic [CW-1:0] yf;
    t_yr_side      yr_out;

    pbw_reduce #(.QW(1), .SW($bits(t_yr_side))) u_red_y (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (yd_valid),
        .i_nearest (yd_out.op),
        .i_neg     (yd_out.neg),
        .i_qmag    (yd_quot[0]),
        .i_rmag    (yd_rem),
        .i_bias    (yd_out.bias),
        .i_len     (r_len_y),
        .i_alow    (yd_out.alow),
        .i_side    ({yd_out.xf, yd_out.zf}),
        .o_valid   (yr_valid),
        .o_count   (),
        .o_coord   (yf),
        .o_side    (yr_out)
    );

    // ---------------- output register + skid
    t_pbw_out res;

    assign res = '{out_x: yr_out.xf, out_y: yf, out_z: yr_out.zf};

    pbw_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (yr_valid),
        .i_data  (res),
        .o_ready (en),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

    assign o_in_ready = en;

endmodule

`default_nettype wire

@@ tb/tb_periodic_box_wrap_core.sv @@
// Testbench of the sheared periodic box wrap core: directed table and random words.
`default_nettype none

module tb_periodic_box_wrap_core;
    timeunit 1ns;
    timeprecision 1ps;
    import pbw_pkg::*;

    localparam logic OP_WRAP    = 1'b0;
    localparam logic OP_NEAREST = 1'b1;
    localparam int LATENCY    = 111;
    localparam int STALL_MAX  = 4000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_pbw_in i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_pbw_out o_out_data;
    logic i_cfg_we = 1'b0;
    logic [2:0] i_cfg_idx = '0;
    logic [30:0] i_cfg_data = '0;

    periodic_box_wrap_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Box settings held by the predictor; mirrors every register write.
    longint box_len[3];      // x, y, z
    longint sh_xy, sh_zx, sh_zy;

    t_pbw_out wrapped_q[$];
    int n_err = 0, n_in = 0, n_out = 0, n_wrap = 0, n_near = 0;
    int idle_cnt = 0;

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch word %0d %s: got %h want %h", n_out, what, got, want);
        n_err++;
    endtask

    // Floor division by a positive divisor.
    function automatic void floor_div(input longint a, input longint d,
                                      output longint q, output longint r);
        q = a / d;
        r = a % d;
        if (r < 0) begin
            r += d;
            q -= 1;
        end
    endfunction

    // Shear offset round(s*n*L/2^16) split into whole lengths and a rest.
    function automatic void shear_split(input longint s, input longint n, input longint len,
                                        output longint k, output longint rest);
        longint f;
        longint unsigned prod;
        floor_div(s * n, 65536, k, f);
        prod = longint'(f) * longint'(len) + 32768;
        rest = longint'(prod >> 16);
    endfunction

    // Image count and reduced coordinate of a - bias*len.
    function automatic void image_reduce(input longint a, input longint bias,
                                         input longint len, input bit nearest,
                                         output longint cnt, output longint c);
        longint q, r;
        if (len == 0) begin
            cnt = 0;
            c = a;
            return;
        end
        floor_div(a, len, q, r);
        q -= bias;
        if (nearest && (2 * r > len || (2 * r == len && q[0]))) begin
            q += 1;
            r -= len;
        end
        cnt = q;
        c = r;
    endfunction

    function automatic t_pbw_out wrap_point(input t_pbw_in w);
        t_pbw_out o;
        longint nz, nx, ny, zf, xf, yf, kzx, rzx, kzy, rzy, kxy, rxy;
        bit nr;
        nr = w.operation;
        image_reduce(longint'(w.pos_z), 0, box_len[2], nr, nz, zf);
        shear_split(sh_zx, nz, box_len[0], kzx, rzx);
        shear_split(sh_zy, nz, box_len[1], kzy, rzy);
        image_reduce(longint'(w.pos_x) - rzx, kzx, box_len[0], nr, nx, xf);
        shear_split(sh_xy, nx, box_len[1], kxy, rxy);
        image_reduce(longint'(w.pos_y) - rzy - rxy, kzy + kxy, box_len[1], nr, ny, yf);
        o.out_x = xf[31:0];
        o.out_y = yf[31:0];
        o.out_z = zf[31:0];
        return o;
    endfunction

    task automatic cfg_write(input t_cfg_idx idx, input longint val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val[30:0];
        case (idx)
            REG_LEN_X:    box_len[0] = val & 64'h7FFF_FFFF;
            REG_LEN_Y:    box_len[1] = val & 64'h7FFF_FFFF;
            REG_LEN_Z:    box_len[2] = val & 64'h7FFF_FFFF;
            REG_SHEAR_XY: sh_xy = longint'($signed(val[17:0]));
            REG_SHEAR_ZX: sh_zx = longint'($signed(val[17:0]));
            REG_SHEAR_ZY: sh_zy = longint'($signed(val[17:0]));
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_box(input longint lx, ly, lz, sxy, szx, szy);
        cfg_write(REG_LEN_X, lx);
        cfg_write(REG_LEN_Y, ly);
        cfg_write(REG_LEN_Z, lz);
        cfg_write(REG_SHEAR_XY, sxy);
        cfg_write(REG_SHEAR_ZX, szx);
        cfg_write(REG_SHEAR_ZY, szy);
    endtask

    // Drain: every expectation met, then let the pipeline settle.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (wrapped_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    // Offer one word with a random gap ahead of it; valid stays up until taken,
    // and is dropped by the next gap or by drain.
    task automatic send_word(input t_pbw_in w, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        wrapped_q.push_back(wrap_point(w));
        n_in++;
        if (w.operation) n_near++; else n_wrap++;
    endtask

    // Receiver: random stall per word, sometimes long stretches with none.
    int stall_left = 0;
    bit calm = 1'b0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (wrapped_q.size() == 0) begin
                    $display("unexpected output word %0d", n_out);
                    n_err++;
                end else begin
                    t_pbw_out want;
                    want = wrapped_q.pop_front();
                    if (o_out_data.out_x !== want.out_x)
                        report("out_x", o_out_data.out_x, want.out_x);
                    if (o_out_data.out_y !== want.out_y)
                        report("out_y", o_out_data.out_y, want.out_y);
                    if (o_out_data.out_z !== want.out_z)
                        report("out_z", o_out_data.out_z, want.out_z);
                end
                n_out++;
                stall_left = calm ? 0 : $urandom_range(0, 7);
                if ($urandom_range(0, 63) == 0) calm = !calm;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Watchdog: cycles with no accepted word on either side.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we)
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= STALL_MAX) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Directed rows; typed results only where obvious (unit box, zero shear).
    typedef struct {
        bit        nearest;
        logic [31:0] x, y, z;
        bit        typed;
        logic [31:0] ex, ey, ez;
    } t_row;

    localparam int NROWS = 12;
    t_row rows[NROWS] = '{
        '{0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1, 32'h0, 32'h0, 32'h0},
        '{0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 32'hFFFF, 32'hFFFF, 32'hFFFF},
        '{0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 32'h0, 32'h0, 32'h0},
        '{0, 32'hFFFF_FFFF, 32'h0001_8000, 32'h0002_0000, 1, 32'hFFFF, 32'h8000, 32'h0},
        '{1, 32'h0000_8000, 32'h0001_8000, 32'hFFFF_8000, 1, 32'h8000, 32'hFFFF_8000,
            32'hFFFF_8000},
        '{1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_7FFF, 1, 32'hFFFF_FFFF, 32'h0,
            32'h7FFF},
        '{1, 32'h0000_8001, 32'hFFFF_7FFF, 32'h0002_8000, 1, 32'hFFFF_8001, 32'h7FFF,
            32'h8000},
        '{1, 32'hAAAA_5555, 32'h5555_AAAA, 32'h1234_5678, 0, 0, 0, 0},
        '{0, 32'hAAAA_5555, 32'h5555_AAAA, 32'hEDCB_A987, 0, 0, 0, 0},
        '{0, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0001, 0, 0, 0, 0},
        '{1, 32'h8000_0001, 32'h0000_0001, 32'h7FFF_FFFE, 0, 0, 0, 0},
        '{1, 32'h0003_0000, 32'hFFFD_0000, 32'h0001_8000, 0, 0, 0, 0}
    };

    function automatic logic [31:0] rand_coord(input longint span);
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            2: return 32'h8000_0000 + $urandom_range(0, 3);
            default: return 32'($signed($urandom_range(0, 8 * span)) - 4 * span);
        endcase
    endfunction

    task automatic random_phase(input int count);
        t_pbw_in w;
        longint span;
        for (int i = 0; i < count; i++) begin
            span = box_len[0] > box_len[1] ? box_len[0] : box_len[1];
            if (box_len[2] > span) span = box_len[2];
            if (span > 64'h0FFF_FFFF) span = 64'h0FFF_FFFF;
            w.operation = 1'($urandom_range(0, 1));
            w.pos_x = rand_coord(span);
            w.pos_y = rand_coord(span);
            w.pos_z = rand_coord(span);
            send_word(w, calm);
        end
    endtask

    function automatic longint rand_len();
        case ($urandom_range(0, 3))
            0: return 65536 + $urandom_range(0, 4 * 65536);
            1: return $urandom_range(65536, 32'h7FFF_FFFF);
            2: return $urandom_range(1, 65535);
            default: return $urandom_range(65536, 64 * 65536);
        endcase
    endfunction

    function automatic longint rand_shear();
        return longint'($signed(18'($urandom())));
    endfunction

    initial begin
        t_pbw_in w;
        box_len = '{65536, 65536, 65536};
        sh_xy = 0; sh_zx = 0; sh_zy = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Unit box after reset: directed rows.
        foreach (rows[i]) begin
            w.operation = rows[i].nearest ? OP_NEAREST : OP_WRAP;
            w.pos_x = rows[i].x;
            w.pos_y = rows[i].y;
            w.pos_z = rows[i].z;
            send_word(w, 1'b0);
            if (rows[i].typed) begin
                wrapped_q[$] = '{out_x: rows[i].ex, out_y: rows[i].ey, out_z: rows[i].ez};
            end
        end
        // Hold the sender until the pipe is empty.
        drain();

        // Extremes: largest lengths with full-scale shears, then zero lengths, then zero y length only.
        set_box(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 131071, -131072, 131071);
        foreach (rows[i]) begin
            w.operation = rows[i].nearest;
            w.pos_x = rows[i].x; w.pos_y = rows[i].y; w.pos_z = rows[i].z;
            send_word(w, 1'b1);
        end
        random_phase(40);
        drain();
        set_box(0, 0, 0, -131072, 131071, -131072);
        random_phase(30);
        drain();
        set_box(65536, 0, 3 * 65536, 65536, -65536, 32768);
        random_phase(30);
        drain();

        // Random boxes and shears, one phase each.
        for (int p = 0; p < 12; p++) begin
            set_box(rand_len(), rand_len(), rand_len(), rand_shear(), rand_shear(),
                    rand_shear());
            random_phase(120);
            drain();
        end

        while (wrapped_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
        $display("covered %0d words (%0d wrap, %0d nearest image) over 16 box settings",
                 n_in, n_wrap, n_near);
        $display("outputs checked %0d, mismatches %0d", n_out, n_err);
        if (n_err == 0 && wrapped_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
rtl/pbw_pkg.sv
rtl/pbw_div.sv
rtl/pbw_reduce.sv
rtl/pbw_offset.sv
rtl/pbw_skid.sv
rtl/periodic_box_wrap_core.sv
tb/tb_periodic_box_wrap_core.sv
